// File: rtl/lrlc_pkg.sv
// Shared types and constants for the logic run-length capture unit.
// No dependencies; imported by logic_run_length_capture_unit.
package lrlc_pkg;

  localparam int unsigned WORD_W  = 16;
  localparam int unsigned FILL_W  = 10;
  localparam int unsigned TOTAL_W = 32;
  localparam int unsigned IDX_W   = 1;

  // Bit of the port word that carries the watched line
  localparam int unsigned LINE_BIT = 9;

  // Register reset values
  localparam logic [WORD_W-1:0] RESET_MAX_RUN   = 16'd20000;
  localparam logic [WORD_W-1:0] RESET_FLAG_MASK = 16'd0;

  // Configuration register indexes
  localparam logic [IDX_W-1:0] REG_MAX_RUN   = 1'b0;
  localparam logic [IDX_W-1:0] REG_FLAG_MASK = 1'b1;

  // Item action codes
  typedef enum logic [0:0] {
    ACT_SAMPLE = 1'b0,
    ACT_POP    = 1'b1
  } action_e;

  // One result item
  typedef struct packed {
    logic [WORD_W-1:0]  read_data;
    logic               read_valid;
    logic [FILL_W-1:0]  fifo_fill;
    logic [TOTAL_W-1:0] overrun_total;
    logic [TOTAL_W-1:0] sample_total;
    logic [TOTAL_W-1:0] pulse_total;
  } res_t;

endpackage

// File: rtl/logic_run_length_capture_unit.sv
// Pipeline: two register stages; a result item passes from stage 1 to stage 2 and is on the
// outputs once stage 2 holds it (stage 1 holds the bookkeeping and the registered FIFO memory
// read, stage 2 is the output register); a stalled output holds both stages.
// Throughput: one item per cycle while the output is not stalled; the two-bank FIFO
// memory takes a counter plus zero pair as one write per bank.
// Reset (rst_ni low, asynchronous): level, run counter, FIFO pointers, fill and
// totals clear; max_run returns to 20000, flag_mask to 0. FIFO storage is not cleared.
module logic_run_length_capture_unit #(
  parameter int unsigned FIFO_DEPTH = 512
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration write port
  input  logic                            cfg_we_i,
  input  logic [lrlc_pkg::IDX_W-1:0]      cfg_idx_i,
  input  logic [lrlc_pkg::WORD_W-1:0]     cfg_data_i,
  // input items
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            action_i,
  input  logic [lrlc_pkg::WORD_W-1:0]     port_word_i,
  // result items
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [lrlc_pkg::WORD_W-1:0]     read_data_o,
  output logic                            read_valid_o,
  output logic [lrlc_pkg::FILL_W-1:0]     fifo_fill_o,
  output logic [lrlc_pkg::TOTAL_W-1:0]    overrun_total_o,
  output logic [lrlc_pkg::TOTAL_W-1:0]    sample_total_o,
  output logic [lrlc_pkg::TOTAL_W-1:0]    pulse_total_o
);
  import lrlc_pkg::*;

  // Words alternate between two banks, so a pair lands one word in each
  localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned BANK_DEPTH = (FIFO_DEPTH + 1) / 2;
  localparam int unsigned BA_W       = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam logic [BA_W-1:0]  BA_LAST    = BA_W'(BANK_DEPTH - 1);
  localparam logic [CNT_W-1:0] LIM_SINGLE = CNT_W'(FIFO_DEPTH - 1);
  localparam logic [CNT_W-1:0] LIM_PAIR   = CNT_W'(FIFO_DEPTH - 2);

  // configuration
  logic [WORD_W-1:0] max_run_q, flag_mask_q;

  // run state and totals
  logic               level_q, level_d;
  logic [WORD_W-1:0]  run_q, run_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [TOTAL_W-1:0] samples_q, samples_d;
  logic [TOTAL_W-1:0] pulses_q, pulses_d;
  logic [TOTAL_W-1:0] overruns_q, overruns_d;

  // FIFO bank pointers
  logic            wsel_q, wsel_d;
  logic            rsel_q, rsel_d;
  logic [BA_W-1:0] waddr_q [2];
  logic [BA_W-1:0] raddr_q [2];

  // FIFO memories
  logic [WORD_W-1:0] mem0 [BANK_DEPTH];
  logic [WORD_W-1:0] mem1 [BANK_DEPTH];
  logic [WORD_W-1:0] rdata0_q, rdata1_q;

  // pipeline
  logic in_acc, adv1, load2;
  logic v1_q, v2_q;
  res_t s1_res_q, s1_res_d;
  logic s1_rd_q, s1_bank_q;
  res_t s2_res_q, s2_res_d;
  logic [WORD_W-1:0] pop_word;

  // item decode
  logic              line_bit;
  logic [WORD_W-1:0] run_inc;
  logic [WORD_W-1:0] word_a;
  logic              push1, push2, rd_en;
  logic              we0, we1, re0, re1;
  logic [WORD_W-1:0] wd0, wd1;
  logic [CNT_W+FILL_W-1:0] fill_ext;

  function automatic logic [BA_W-1:0] bump(input logic [BA_W-1:0] ptr);
    return (ptr == BA_LAST) ? '0 : ptr + BA_W'(1);
  endfunction

  // handshake: stage 1 takes an item whenever it is empty or moves on
  assign adv1       = !v2_q || out_ready_i;
  assign in_ready_o = !v1_q || adv1;
  assign in_acc     = in_valid_i && in_ready_o;
  assign load2      = v1_q && adv1;

  assign line_bit = port_word_i[LINE_BIT];
  assign run_inc  = run_q + WORD_W'(1);

  // run tracking, push decisions and FIFO bookkeeping
  always_comb begin
    level_d    = level_q;
    run_d      = run_q;
    samples_d  = samples_q;
    pulses_d   = pulses_q;
    overruns_d = overruns_q;
    wsel_d     = wsel_q;
    rsel_d     = rsel_q;
    push1      = 1'b0;
    push2      = 1'b0;
    rd_en      = 1'b0;
    word_a     = run_q | flag_mask_q;
    if (in_acc) begin
      unique case (action_e'(action_i))
        ACT_POP: begin
          if (count_q != '0) begin
            rd_en  = 1'b1;
            rsel_d = !rsel_q;
          end
        end
        ACT_SAMPLE: begin
          samples_d = samples_q + TOTAL_W'(1);
          if (line_bit == level_q) begin
            run_d = run_inc;
            if (run_inc >= max_run_q) begin
              run_d = '0;
              if (count_q < LIM_PAIR) begin
                push2  = 1'b1;
                word_a = run_inc | flag_mask_q;
              end else begin
                overruns_d = overruns_q + TOTAL_W'(1);
              end
            end
          end else begin
            if (count_q < LIM_SINGLE) begin
              push1  = 1'b1;
              wsel_d = !wsel_q;
            end else begin
              overruns_d = overruns_q + TOTAL_W'(1);
            end
            run_d    = '0;
            level_d  = !level_q;
            pulses_d = pulses_q + TOTAL_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // fill count: one or two words in, or one word out
  always_comb begin
    count_d = count_q;
    if (push2) begin
      count_d = count_q + CNT_W'(2);
    end else if (push1) begin
      count_d = count_q + CNT_W'(1);
    end else if (rd_en) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  // bank write and read enables; the second word of a pair is the bare mask
  assign we0 = (push1 && !wsel_q) || push2;
  assign we1 = (push1 && wsel_q) || push2;
  assign wd0 = (push2 && wsel_q) ? flag_mask_q : word_a;
  assign wd1 = (push2 && !wsel_q) ? flag_mask_q : word_a;
  assign re0 = rd_en && !rsel_q;
  assign re1 = rd_en && rsel_q;

  // stage 1 result: everything but the popped word
  assign fill_ext = (CNT_W + FILL_W)'(count_d);
  always_comb begin
    s1_res_d               = '0;
    s1_res_d.read_valid    = rd_en;
    s1_res_d.fifo_fill     = fill_ext[FILL_W-1:0];
    s1_res_d.overrun_total = overruns_d;
    s1_res_d.sample_total  = samples_d;
    s1_res_d.pulse_total   = pulses_d;
  end

  // stage 2 result: stage 1 result with the popped word merged in
  assign pop_word = s1_rd_q ? (s1_bank_q ? rdata1_q : rdata0_q) : '0;
  always_comb begin
    s2_res_d           = s1_res_q;
    s2_res_d.read_data = pop_word;
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_run_q   <= RESET_MAX_RUN;
      flag_mask_q <= RESET_FLAG_MASK;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MAX_RUN:   max_run_q   <= cfg_data_i;
        REG_FLAG_MASK: flag_mask_q <= cfg_data_i;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q    <= 1'b0;
      run_q      <= '0;
      count_q    <= '0;
      samples_q  <= '0;
      pulses_q   <= '0;
      overruns_q <= '0;
      wsel_q     <= 1'b0;
      rsel_q     <= 1'b0;
      waddr_q[0] <= '0;
      waddr_q[1] <= '0;
      raddr_q[0] <= '0;
      raddr_q[1] <= '0;
      v1_q       <= 1'b0;
      v2_q       <= 1'b0;
    end else begin
      level_q    <= level_d;
      run_q      <= run_d;
      count_q    <= count_d;
      samples_q  <= samples_d;
      pulses_q   <= pulses_d;
      overruns_q <= overruns_d;
      wsel_q     <= wsel_d;
      rsel_q     <= rsel_d;
      if (we0) waddr_q[0] <= bump(waddr_q[0]);
      if (we1) waddr_q[1] <= bump(waddr_q[1]);
      if (re0) raddr_q[0] <= bump(raddr_q[0]);
      if (re1) raddr_q[1] <= bump(raddr_q[1]);
      if (in_acc) begin
        v1_q <= 1'b1;
      end else if (adv1) begin
        v1_q <= 1'b0;
      end
      if (load2) begin
        v2_q <= 1'b1;
      end else if (out_ready_i) begin
        v2_q <= 1'b0;
      end
    end
  end

  // FIFO bank 0
  always_ff @(posedge clk_i) begin
    if (we0) mem0[waddr_q[0]] <= wd0;
    if (re0) rdata0_q <= mem0[raddr_q[0]];
  end

  // FIFO bank 1
  always_ff @(posedge clk_i) begin
    if (we1) mem1[waddr_q[1]] <= wd1;
    if (re1) rdata1_q <= mem1[raddr_q[1]];
  end

  // pipeline payload; the read data register holds until stage 1 moves on
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_res_q  <= s1_res_d;
      s1_rd_q   <= rd_en;
      s1_bank_q <= rsel_q;
    end
    if (load2) begin
      s2_res_q <= s2_res_d;
    end
  end

  assign out_valid_o     = v2_q;
  assign read_data_o     = s2_res_q.read_data;
  assign read_valid_o    = s2_res_q.read_valid;
  assign fifo_fill_o     = s2_res_q.fifo_fill;
  assign overrun_total_o = s2_res_q.overrun_total;
  assign sample_total_o  = s2_res_q.sample_total;
  assign pulse_total_o   = s2_res_q.pulse_total;

  // fill never passes the depth
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(FIFO_DEPTH))
    else $error("FIFO fill count exceeds depth");

  // bank selects differ exactly when an odd number of words is held
  a_bank_parity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wsel_q ^ rsel_q) == count_q[0])
    else $error("bank selects out of step with fill count");

  // a pop from a non-empty FIFO takes exactly one word
  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && action_i == ACT_POP && count_q != '0) |=>
      count_q == $past(count_q) - CNT_W'(1))
    else $error("pop did not remove one word");

  // a level change toggles the level and counts a pulse
  a_level_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && action_i == ACT_SAMPLE && line_bit != level_q) |=>
      (level_q != $past(level_q)) && (pulses_q == $past(pulses_q) + TOTAL_W'(1)))
    else $error("level change not tracked");

endmodule

// File: bench/logic_run_length_capture_unit_tb.sv
// Self-checking bench for logic_run_length_capture_unit: a directed table, a FIFO overflow
// scenario and random phases, checked against table values or an in-bench capture predictor.
// Depends on lrlc_pkg and the unit itself; reads no files.
module logic_run_length_capture_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lrlc_pkg::*;

  localparam int unsigned DEPTH       = 512;
  localparam int unsigned HOLD_CYCLES = 400;

  typedef enum logic {STEP_ITEM, STEP_CFG} step_kind_e;

  // One row of the directed table; for a register row, word is max_run and mask is flag_mask
  typedef struct packed {
    step_kind_e        kind;
    action_e           act;
    logic [WORD_W-1:0] word;
    logic [WORD_W-1:0] mask;
    logic              typed;
    res_t              want;
  } step_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [IDX_W-1:0]    cfg_idx_i;
  logic [WORD_W-1:0]   cfg_data_i;
  logic                in_valid_i;
  logic                in_ready_o;
  logic                action_i;
  logic [WORD_W-1:0]   port_word_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [WORD_W-1:0]   read_data_o;
  logic                read_valid_o;
  logic [FILL_W-1:0]   fifo_fill_o;
  logic [TOTAL_W-1:0]  overrun_total_o;
  logic [TOTAL_W-1:0]  sample_total_o;
  logic [TOTAL_W-1:0]  pulse_total_o;

  logic_run_length_capture_unit #(.FIFO_DEPTH(DEPTH)) DUT (.*);

  // Predictor state: registers, line tracking, FIFO copy and totals
  logic [WORD_W-1:0]  run_limit = RESET_MAX_RUN;
  logic [WORD_W-1:0]  or_mask   = RESET_FLAG_MASK;
  logic               line_level = 1'b0;
  logic [WORD_W-1:0]  run_len    = '0;
  logic [WORD_W-1:0]  ring [DEPTH];
  logic [8:0]         head_ptr   = '0;
  logic [8:0]         tail_ptr   = '0;
  logic [9:0]         fill_count = '0;
  logic [TOTAL_W-1:0] sample_count  = '0;
  logic [TOTAL_W-1:0] pulse_count   = '0;
  logic [TOTAL_W-1:0] overrun_count = '0;

  res_t        awaited_results [$];
  step_t       plan [$];
  int unsigned faults       = 0;
  int unsigned items_sent   = 0;
  int unsigned words_popped = 0;
  int unsigned cfg_writes   = 0;
  logic        hold_req = 1'b0;
  logic        tx_idle  = 1'b1;
  logic        rx_idle  = 1'b1;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Hard stop, several times the slowest legal run
  initial begin
    #5_000_000;
    $display("logic_run_length_capture_unit_tb: FAIL");
    $finish;
  end

  function automatic void ring_push(logic [WORD_W-1:0] word);
    ring[tail_ptr] = word | or_mask;
    tail_ptr       = tail_ptr + 1'b1;
    fill_count     = fill_count + 1'b1;
  endfunction

  // Advance the capture state by one item and return the result it causes
  function automatic res_t predict_capture(action_e act, logic [WORD_W-1:0] word);
    res_t        r;
    logic [16:0] bumped;
    r = '0;
    if (act == ACT_POP) begin
      if (fill_count != 0) begin
        r.read_data  = ring[head_ptr];
        r.read_valid = 1'b1;
        head_ptr     = head_ptr + 1'b1;
        fill_count   = fill_count - 1'b1;
        words_popped++;
      end
    end else begin
      sample_count = sample_count + 1'b1;
      if (word[LINE_BIT] == line_level) begin
        bumped = {1'b0, run_len} + 17'd1;
        if (bumped >= {1'b0, run_limit}) begin
          // split: counter then zero, only with room for both
          if (DEPTH - int'(fill_count) > 2) begin
            ring_push(bumped[WORD_W-1:0]);
            ring_push('0);
          end else begin
            overrun_count = overrun_count + 1'b1;
          end
          run_len = '0;
        end else begin
          run_len = bumped[WORD_W-1:0];
        end
      end else begin
        // level change closes the run
        if (DEPTH - int'(fill_count) > 1) ring_push(run_len);
        else overrun_count = overrun_count + 1'b1;
        run_len     = '0;
        line_level  = ~line_level;
        pulse_count = pulse_count + 1'b1;
      end
    end
    r.fifo_fill     = fill_count;
    r.overrun_total = overrun_count;
    r.sample_total  = sample_count;
    r.pulse_total   = pulse_count;
    return r;
  endfunction

  function automatic res_t outcome(logic [WORD_W-1:0] data, logic valid, logic [FILL_W-1:0] fill,
                                   logic [TOTAL_W-1:0] over, logic [TOTAL_W-1:0] samp,
                                   logic [TOTAL_W-1:0] pulse);
    res_t r;
    r.read_data     = data;
    r.read_valid    = valid;
    r.fifo_fill     = fill;
    r.overrun_total = over;
    r.sample_total  = samp;
    r.pulse_total   = pulse;
    return r;
  endfunction

  function automatic step_t item_row(action_e act, logic [WORD_W-1:0] word, logic typed,
                                     res_t want);
    step_t s;
    s.kind  = STEP_ITEM;
    s.act   = act;
    s.word  = word;
    s.mask  = '0;
    s.typed = typed;
    s.want  = want;
    return s;
  endfunction

  function automatic step_t cfg_row(logic [WORD_W-1:0] new_limit, logic [WORD_W-1:0] mask);
    step_t s;
    s       = '0;
    s.kind  = STEP_CFG;
    s.word  = new_limit;
    s.mask  = mask;
    return s;
  endfunction

  // Random port word with the watched line forced to the given level
  function automatic logic [WORD_W-1:0] line_word(logic lvl);
    logic [WORD_W-1:0] w;
    w           = WORD_W'($urandom);
    w[LINE_BIT] = lvl;
    return w;
  endfunction

  // Offer one item, wait for it to be taken, then record its expected result
  task automatic send_item(action_e act, logic [WORD_W-1:0] word, logic typed = 1'b0,
                           res_t want = '0);
    res_t predicted;
    if (tx_idle && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    action_i    <= act;
    port_word_i <= word;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predicted = predict_capture(act, word);
    awaited_results.push_back(typed ? want : predicted);
    items_sent++;
  endtask

  // Stop offering and let every outstanding result come back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // Write both registers back to back; only called with the unit idle
  task automatic configure(logic [WORD_W-1:0] new_limit, logic [WORD_W-1:0] mask);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_MAX_RUN;
    cfg_data_i <= new_limit;
    @(posedge clk_i);
    cfg_idx_i  <= REG_FLAG_MASK;
    cfg_data_i <= mask;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    @(posedge clk_i);
    run_limit  = new_limit;
    or_mask    = mask;
    cfg_writes += 2;
  endtask

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      faults++;
    end
  endtask

  // Result checker: every accepted result against the oldest expectation
  always @(posedge clk_i) begin : result_check
    res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (awaited_results.size() == 0) begin
        $display("%0t ns: result with nothing expected, got data %0h", $time, read_data_o);
        faults++;
      end else begin
        want = awaited_results.pop_front();
        compare_field("read_data", want.read_data, read_data_o);
        compare_field("read_valid", want.read_valid, read_valid_o);
        compare_field("fifo_fill", want.fifo_fill, fifo_fill_o);
        compare_field("overrun_total", want.overrun_total, overrun_total_o);
        compare_field("sample_total", want.sample_total, sample_total_o);
        compare_field("pulse_total", want.pulse_total, pulse_total_o);
      end
    end
  end

  // Receiver: random ready bursts, plus one long hold-off on request
  initial begin : receiver
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (rx_idle && $urandom_range(0, 4) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
  end

  // Stimulus
  initial begin : stimulus
    logic [WORD_W-1:0] lim;
    logic [WORD_W-1:0] msk;
    int unsigned       cap;
    int unsigned       run_left;
    int unsigned       pop_pct;
    logic              want_bit;
    logic              last_leg;

    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = REG_MAX_RUN;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    action_i    = ACT_SAMPLE;
    port_word_i = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table: reset defaults, empty pops, ignored port word on pop, extremes
    plan.push_back(item_row(ACT_POP,    16'h0000, 1'b1, outcome(16'h0, 1'b0, 10'd0, 0, 0, 0)));
    plan.push_back(item_row(ACT_SAMPLE, 16'h0000, 1'b1, outcome(16'h0, 1'b0, 10'd0, 0, 1, 0)));
    plan.push_back(item_row(ACT_SAMPLE, 16'hFDFF, 1'b1, outcome(16'h0, 1'b0, 10'd0, 0, 2, 0)));
    plan.push_back(item_row(ACT_SAMPLE, 16'h0200, 1'b1, outcome(16'h0, 1'b0, 10'd1, 0, 3, 1)));
    plan.push_back(item_row(ACT_SAMPLE, 16'hFFFF, 1'b1, outcome(16'h0, 1'b0, 10'd1, 0, 4, 1)));
    plan.push_back(item_row(ACT_POP,    16'hFFFF, 1'b1, outcome(16'h2, 1'b1, 10'd0, 0, 4, 1)));
    plan.push_back(item_row(ACT_POP,    16'hFFFF, 1'b1, outcome(16'h0, 1'b0, 10'd0, 0, 4, 1)));
    plan.push_back(item_row(ACT_SAMPLE, 16'h0000, 1'b1, outcome(16'h0, 1'b0, 10'd1, 0, 5, 2)));
    plan.push_back(item_row(ACT_POP,    16'h0000, 1'b1, outcome(16'h1, 1'b1, 10'd0, 0, 5, 2)));
    // max_run of zero splits on every sample at the tracked level; full flag mask
    plan.push_back(cfg_row(16'd0, 16'hFFFF));
    plan.push_back(item_row(ACT_SAMPLE, 16'h0000, 1'b1, outcome(16'h0, 1'b0, 10'd2, 0, 6, 2)));
    plan.push_back(item_row(ACT_POP,    16'h0000, 1'b1, outcome(16'hFFFF, 1'b1, 10'd1, 0, 6, 2)));
    plan.push_back(item_row(ACT_POP,    16'h0000, 1'b1, outcome(16'hFFFF, 1'b1, 10'd0, 0, 6, 2)));
    plan.push_back(item_row(ACT_SAMPLE, 16'hFFFF, 1'b1, outcome(16'h0, 1'b0, 10'd1, 0, 7, 3)));
    // largest max_run, mask cleared; stored word keeps the old mask
    plan.push_back(cfg_row(16'hFFFF, 16'h0000));
    plan.push_back(item_row(ACT_POP,    16'h1234, 1'b1, outcome(16'hFFFF, 1'b1, 10'd0, 0, 7, 3)));
    plan.push_back(cfg_row(16'd3, 16'h5A5A));
    plan.push_back(item_row(ACT_SAMPLE, 16'hFFFF, 1'b0, '0));
    plan.push_back(item_row(ACT_SAMPLE, 16'h8201, 1'b0, '0));
    plan.push_back(item_row(ACT_SAMPLE, 16'hA5A5, 1'b0, '0));
    plan.push_back(item_row(ACT_SAMPLE, 16'h0000, 1'b0, '0));
    plan.push_back(item_row(ACT_POP,    16'h0000, 1'b0, '0));
    plan.push_back(item_row(ACT_POP,    16'hFFFF, 1'b0, '0));
    plan.push_back(item_row(ACT_SAMPLE, 16'h7DFE, 1'b0, '0));
    plan.push_back(item_row(ACT_POP,    16'h0000, 1'b0, '0));
    plan.push_back(item_row(ACT_POP,    16'h0000, 1'b0, '0));

    foreach (plan[i]) begin
      if (plan[i].kind == STEP_CFG) begin
        drain_results();
        configure(plan[i].word, plan[i].mask);
      end else begin
        send_item(plan[i].act, plan[i].word, plan[i].typed, plan[i].want);
      end
    end

    // Fill to the brim with the receiver held off, then probe both refusal limits
    drain_results();
    configure(16'd1, WORD_W'($urandom));
    hold_req = 1'b1;
    while (fill_count < 10'(DEPTH - 2)) send_item(ACT_SAMPLE, line_word(line_level));
    repeat (2) send_item(ACT_SAMPLE, line_word(line_level));
    send_item(ACT_SAMPLE, line_word(~line_level));
    send_item(ACT_SAMPLE, line_word(line_level));
    send_item(ACT_SAMPLE, line_word(~line_level));
    repeat (2) send_item(ACT_POP, WORD_W'($urandom));
    send_item(ACT_SAMPLE, line_word(line_level));
    while (fill_count != 0) send_item(ACT_POP, WORD_W'($urandom));
    send_item(ACT_POP, WORD_W'($urandom));

    // Random phases: random-length runs up to 3*max_run+1 (or 24), pops mixed in, some noise
    for (int ph = 0; ph < 8; ph++) begin
      drain_results();
      if (ph == 0) begin
        lim = 16'hFFFF;
        msk = 16'h0000;
      end else if (ph == 1) begin
        lim = 16'd1;
        msk = 16'hFFFF;
      end else begin
        lim = ($urandom_range(0, 3) == 0) ? WORD_W'($urandom_range(1, 65535))
                                           : WORD_W'($urandom_range(1, 12));
        msk = ($urandom_range(0, 3) == 0) ? 16'h0000 : WORD_W'($urandom);
      end
      configure(lim, msk);
      pop_pct  = (ph == 1) ? 15 : $urandom_range(10, 70);
      cap      = (lim <= 16) ? 3 * int'(lim) + 1 : 24;
      last_leg = (ph == 7);
      tx_idle  = !last_leg && ($urandom_range(0, 3) != 0);
      rx_idle  = !last_leg && ($urandom_range(0, 3) != 0);
      want_bit = line_level;
      run_left = $urandom_range(0, cap);
      repeat (last_leg ? 200 : 130) begin
        if ($urandom_range(1, 100) <= pop_pct) begin
          send_item(ACT_POP, WORD_W'($urandom));
        end else if ($urandom_range(0, 19) == 0) begin
          send_item(ACT_SAMPLE, WORD_W'($urandom));
        end else begin
          send_item(ACT_SAMPLE, line_word(want_bit));
          if (run_left == 0) begin
            want_bit = ~want_bit;
            run_left = $urandom_range(0, cap);
          end else begin
            run_left--;
          end
        end
      end
    end

    // Wind down: everything back, then a quiet stretch for strays
    drain_results();
    repeat (8) @(posedge clk_i);
    $display("Run covered %0d items (%0d samples, %0d words popped) and %0d register writes;",
             items_sent, sample_count, words_popped, cfg_writes);
    $display("%0d level changes and %0d refused FIFO writes were predicted.",
             pulse_count, overrun_count);
    if (faults == 0 && awaited_results.size() == 0) begin
      $display("logic_run_length_capture_unit_tb: PASS");
    end else begin
      $display("logic_run_length_capture_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
